>>> rtl/pde_pkg.sv
// Shared widths, the queue entry type and the control struct for the polyline delta encoder.
// No dependencies.
package pde_pkg;

  localparam int LINE_W  = 24;
  localparam int LON_W   = 29;
  localparam int LAT_W   = 28;
  localparam int CUR_W   = 32;
  localparam int DELTA_W = 16;
  localparam int PREV_W  = 25;

  // One classified point as it travels from the front to the back.
  typedef struct packed {
    logic signed [LON_W-1:0] start_lon;
    logic signed [LAT_W-1:0] start_lat;
    logic signed [LON_W-1:0] point_lon;
    logic signed [LAT_W-1:0] point_lat;
    logic                    starts_line;
    logic                    order_error;
  } entry_t;

  // Handshake between the queue and the back part.
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

endpackage

>>> rtl/pde_if.sv
// Channel interfaces for points in and encoded steps out.
// Depends on pde_pkg.
interface pde_in_if;
  logic                             valid;
  logic                             ready;
  logic        [pde_pkg::LINE_W-1:0] point_line;
  logic signed [pde_pkg::LON_W-1:0]  start_lon;
  logic signed [pde_pkg::LAT_W-1:0]  start_lat;
  logic signed [pde_pkg::LON_W-1:0]  point_lon;
  logic signed [pde_pkg::LAT_W-1:0]  point_lat;
  modport source (output valid, point_line, start_lon, start_lat, point_lon, point_lat,
                  input ready);
  modport sink (input valid, point_line, start_lon, start_lat, point_lon, point_lat,
                output ready);
endinterface

interface pde_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pde_pkg::DELTA_W-1:0] delta_lon;
  logic signed [pde_pkg::DELTA_W-1:0] delta_lat;
  logic                               is_midpoint;
  logic                               starts_line;
  logic                               order_error;
  logic                               range_error;
  logic                               last;
  modport source (output valid, delta_lon, delta_lat, is_midpoint, starts_line, order_error,
                  range_error, last, input ready);
  modport sink (input valid, delta_lon, delta_lat, is_midpoint, starts_line, order_error,
                range_error, last, output ready);
endinterface

>>> rtl/pde_front.sv
// Front part: accepts points, tracks the line id and classifies line changes.
// Depends on pde_pkg and pde_if.
module pde_front (
  input  logic            clk,
  input  logic            rst,
  pde_in_if.sink          in_pt,
  input  logic            q_full,
  output logic            push,
  output pde_pkg::entry_t push_entry
);

  logic signed [pde_pkg::PREV_W-1:0] previous_line;
  logic signed [pde_pkg::PREV_W-1:0] line_s;

  assign line_s      = $signed({1'b0, in_pt.point_line});
  assign in_pt.ready = !q_full;
  assign push        = in_pt.valid && !q_full;

  always_comb begin
    push_entry.start_lon   = in_pt.start_lon;
    push_entry.start_lat   = in_pt.start_lat;
    push_entry.point_lon   = in_pt.point_lon;
    push_entry.point_lat   = in_pt.point_lat;
    push_entry.starts_line = (line_s != previous_line);
    push_entry.order_error = (previous_line > line_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_line <= '1;
    end else if (push) begin
      previous_line <= line_s;
    end
  end

endmodule

>>> rtl/pde_queue.sv
// Two-entry queue that decouples the front part from the back part.
// Depends on pde_pkg.
module pde_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  pde_pkg::entry_t      push_entry,
  output logic                 full,
  input  logic                 pop,
  output pde_pkg::queue_head_t head
);

  pde_pkg::entry_t store [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.entry = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/pde_back.sv
// Back part: owns the cursor, generates midpoints with a bit-serial divider and
// holds the output register. Depends on pde_pkg and pde_if.
module pde_back #(
  parameter int MAX_MIDPOINTS = 63,
  parameter int DELTA_LIMIT   = 32767
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pde_pkg::queue_head_t head,
  output logic                 pop,
  pde_out_if.source            out_res
);

  localparam int QW = $clog2(DELTA_LIMIT + 1);
  localparam int NW = $clog2(MAX_MIDPOINTS + 1);
  localparam int PW = pde_pkg::CUR_W + QW;
  localparam int IW = $clog2(QW);
  localparam int CW = pde_pkg::CUR_W;
  localparam int DW = pde_pkg::DELTA_W;
  localparam logic signed [CW-1:0] DL   = CW'(DELTA_LIMIT);
  localparam logic signed [DW-1:0] DL16 = DW'(DELTA_LIMIT);
  localparam logic [QW-1:0] DLQ = QW'(DELTA_LIMIT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]              state;
  pde_pkg::entry_t         ent;
  logic signed [CW-1:0]    cur_lon;
  logic signed [CW-1:0]    cur_lat;
  logic                    first;
  logic [NW-1:0]           cnt;
  logic [CW-1:0]           maj_mag;
  logic [CW-1:0]           min_mag;
  logic                    maj_neg;
  logic                    min_neg;
  logic                    y_major;
  logic [PW-1:0]           rem;
  logic [QW-1:0]           quo;
  logic [IW-1:0]           bit_i;
  logic signed [DW-1:0]    e_lon;
  logic signed [DW-1:0]    e_lat;
  logic                    e_mid;
  logic                    e_rerr;

  logic signed [CW-1:0] plon, plat, dx, dy;
  logic [CW-1:0]        ax, ay;
  logic                 far;
  logic [PW-1:0]        div_sh;
  logic signed [DW-1:0] maj_step, min_step, sat_x, sat_y;
  logic                 out_free;

  assign plon     = CW'(ent.point_lon);
  assign plat     = CW'(ent.point_lat);
  assign dx       = plon - cur_lon;
  assign dy       = plat - cur_lat;
  assign ax       = dx[CW-1] ? CW'(-dx) : CW'(dx);
  assign ay       = dy[CW-1] ? CW'(-dy) : CW'(dy);
  assign far      = (ax > CW'(DL)) || (ay > CW'(DL));
  assign sat_x    = (dx > DL) ? DL16 : ((dx < -DL) ? -DL16 : DW'(dx));
  assign sat_y    = (dy > DL) ? DL16 : ((dy < -DL) ? -DL16 : DW'(dy));
  assign div_sh   = PW'(maj_mag) << bit_i;
  assign maj_step = maj_neg ? -DL16 : DL16;
  assign min_step = min_neg ? -$signed(DW'(quo)) : $signed(DW'(quo));
  assign out_free = !out_res.valid || out_res.ready;
  assign pop      = (state == S_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_res.valid <= 1'b0;
    end else begin
      // The emit state sets valid itself when the register is free.
      if (out_res.ready && (state != S_EMIT)) out_res.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            ent   <= head.entry;
            first <= head.entry.starts_line;
            cnt   <= '0;
            if (head.entry.starts_line) begin
              cur_lon <= CW'(head.entry.start_lon);
              cur_lat <= CW'(head.entry.start_lat);
            end
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          y_major <= (ay > ax);
          if (ay > ax) begin
            maj_mag <= ay;
            min_mag <= ax;
            maj_neg <= dy[CW-1];
            min_neg <= dx[CW-1];
          end else begin
            maj_mag <= ax;
            min_mag <= ay;
            maj_neg <= dx[CW-1];
            min_neg <= dy[CW-1];
          end
          if (far && (32'(cnt) < 32'(MAX_MIDPOINTS))) begin
            state <= S_MUL;
          end else begin
            e_lon  <= sat_x;
            e_lat  <= sat_y;
            e_mid  <= 1'b0;
            e_rerr <= far;
            state  <= S_EMIT;
          end
        end
        S_MUL: begin
          rem   <= PW'(min_mag) * PW'(DLQ);
          quo   <= '0;
          bit_i <= IW'(QW - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          if (rem >= div_sh) begin
            rem        <= rem - div_sh;
            quo[bit_i] <= 1'b1;
          end
          if (bit_i == '0) begin
            state <= S_EMIT;
          end
          bit_i <= bit_i - 1'b1;
        end
        S_EMIT: begin
          if (out_free) begin
            out_res.valid       <= 1'b1;
            out_res.is_midpoint <= e_mid;
            out_res.starts_line <= first;
            out_res.order_error <= ent.order_error;
            out_res.range_error <= e_rerr;
            out_res.last        <= !e_mid;
            first <= 1'b0;
            cnt   <= cnt + 1'b1;
            if (e_mid) begin
              out_res.delta_lon <= y_major ? min_step : maj_step;
              out_res.delta_lat <= y_major ? maj_step : min_step;
              cur_lon <= cur_lon + CW'(y_major ? min_step : maj_step);
              cur_lat <= cur_lat + CW'(y_major ? maj_step : min_step);
              state   <= S_EVAL;
            end else begin
              out_res.delta_lon <= e_lon;
              out_res.delta_lat <= e_lat;
              cur_lon <= plon;
              cur_lat <= plat;
              state   <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // A finished division always produces a midpoint.
      if (state == S_DIV) e_mid <= 1'b1;
      if (state == S_DIV) e_rerr <= 1'b0;
    end
  end

endmodule

>>> rtl/polyline_delta_encoder.sv
// Top level of the polyline delta encoder: front, queue and back part.
// Depends on pde_pkg, pde_if, pde_front, pde_queue and pde_back.
//
//   Channel   Direction  Carries
//   in_pt     sink       line id, line start position and point position
//   out_res   source     16-bit steps and flags, one or more per point
//
// A point with no midpoint passes the back part's idle, evaluate and emit states.
// Each midpoint passes the evaluate, multiply, divide and emit states, and the
// bit-serial divider works out the minor axis step one quotient bit a cycle.
// Reset is synchronous and clears the queue, the line tracker and the output valid.
// The two-entry queue lets the front keep accepting points while the back waits
// for the output register to be taken, and either side may stall on its own.
module polyline_delta_encoder #(
  parameter int MAX_MIDPOINTS = 63,
  parameter int DELTA_LIMIT   = 32767
) (
  input logic        clk,
  input logic        rst,
  pde_in_if.sink     in_pt,
  pde_out_if.source  out_res
);

  logic                 q_full;
  logic                 push;
  logic                 pop;
  pde_pkg::entry_t      push_entry;
  pde_pkg::queue_head_t head;

  // The front classifies each point as a line change or not, and flags a
  // decreasing line id, before the cursor is ever touched.
  pde_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_pt      (in_pt),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  pde_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head)
  );

  // The back part owns the cursor and emits each transfer through its output register.
  pde_back #(
    .MAX_MIDPOINTS (MAX_MIDPOINTS),
    .DELTA_LIMIT   (DELTA_LIMIT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule

>>> rtl/pde_checker.sv
// Port-level checks for the polyline delta encoder, bound to the top level.
// Depends on polyline_delta_encoder.
module pde_props (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] delta_lon,
  input logic [15:0] delta_lat,
  input logic        is_midpoint,
  input logic        range_error,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_mid_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_midpoint != last))
    else $error("midpoint and last flags disagree");

  a_range_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> last)
    else $error("range error on a midpoint");

  a_no_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (delta_lon != 16'h8000) && (delta_lat != 16'h8000))
    else $error("step outside the saturated range");

endmodule

bind polyline_delta_encoder pde_props u_pde_props (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .delta_lon   (out_res.delta_lon),
  .delta_lat   (out_res.delta_lat),
  .is_midpoint (out_res.is_midpoint),
  .range_error (out_res.range_error),
  .last        (out_res.last)
);

>>> tb/sv/pde_checker.sv
// Checker for the polyline delta encoder: watches both channels, predicts the steps
// and compares them. Depends on pde_pkg and pde_if.
module pde_checker #(
  parameter int MAX_MIDPOINTS = 63,
  parameter int DELTA_LIMIT   = 32767
) (
  input  logic clk,
  input  logic rst,
  pde_in_if    in_pt,
  pde_out_if   out_res,
  output int   fail_count,
  output int   pending,
  output bit   transfer_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [pde_pkg::DELTA_W-1:0] dlon;
    logic [pde_pkg::DELTA_W-1:0] dlat;
    bit mid, starts, oerr, rerr, last;
  } step_t;

  step_t  expected_steps[$];
  longint cur_lon, cur_lat;
  int     prev_line;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clip(longint v);
    if (v > DELTA_LIMIT) return DELTA_LIMIT;
    if (v < -DELTA_LIMIT) return -DELTA_LIMIT;
    return v;
  endfunction

  function automatic step_t mk(longint dlon, longint dlat, bit mid, bit st, bit oe, bit re,
                               bit lst);
    step_t s;
    s.dlon = dlon[15:0];
    s.dlat = dlat[15:0];
    s.mid = mid;
    s.starts = st;
    s.oerr = oe;
    s.rerr = re;
    s.last = lst;
    return s;
  endfunction

  // Works out every step caused by one point and queues them in order.
  task automatic encode_point(int line, longint slon, longint slat, longint plon,
                              longint plat);
    bit     st, oe;
    int     n;
    longint dx, dy, sx, sy;
    st = 0;
    oe = 0;
    n = 0;
    if (line != prev_line) begin
      oe = prev_line > line;
      cur_lon = slon;
      cur_lat = slat;
      prev_line = line;
      st = 1;
    end
    dx = plon - cur_lon;
    dy = plat - cur_lat;
    while ((mag(dx) > DELTA_LIMIT || mag(dy) > DELTA_LIMIT) && n < MAX_MIDPOINTS) begin
      if (dx == 0) begin
        sx = 0;
        sy = dy > DELTA_LIMIT ? DELTA_LIMIT : -DELTA_LIMIT;
      end else if (mag(dy) <= mag(dx)) begin
        sx = dx > 0 ? DELTA_LIMIT : -DELTA_LIMIT;
        sy = (dy * DELTA_LIMIT) / mag(dx);
      end else begin
        sy = dy > 0 ? DELTA_LIMIT : -DELTA_LIMIT;
        sx = (dx * DELTA_LIMIT) / mag(dy);
      end
      expected_steps.push_back(mk(sx, sy, 1, st && n == 0, oe, 0, 0));
      cur_lon += sx;
      cur_lat += sy;
      dx = plon - cur_lon;
      dy = plat - cur_lat;
      n++;
    end
    expected_steps.push_back(mk(clip(dx), clip(dy), 0, st && n == 0, oe,
                                mag(dx) > DELTA_LIMIT || mag(dy) > DELTA_LIMIT, 1));
    cur_lon = plon;
    cur_lat = plat;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    transfer_seen = 0;
    cur_lon = 0;
    cur_lat = 0;
    prev_line = -1;
  end

  // Sampled at the falling edge: handshake signals are stable until the next rising edge.
  always @(negedge clk) begin
    step_t e;
    transfer_seen = 0;
    if (!rst) begin
      if (in_pt.valid && in_pt.ready) begin
        transfer_seen = 1;
        encode_point(int'(in_pt.point_line), longint'(in_pt.start_lon),
                     longint'(in_pt.start_lat), longint'(in_pt.point_lon),
                     longint'(in_pt.point_lat));
      end
      if (out_res.valid && out_res.ready) begin
        transfer_seen = 1;
        if (expected_steps.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected step transfer at %0t", $realtime);
        end else begin
          e = expected_steps.pop_front();
          if (out_res.delta_lon !== e.dlon || out_res.delta_lat !== e.dlat ||
              out_res.is_midpoint !== e.mid || out_res.starts_line !== e.starts ||
              out_res.order_error !== e.oerr || out_res.range_error !== e.rerr ||
              out_res.last !== e.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("step mismatch at %0t: exp %0d %0d m%0b s%0b o%0b r%0b l%0b, got %0d %0d m%0b s%0b o%0b r%0b l%0b",
                       $realtime, $signed(e.dlon), $signed(e.dlat), e.mid, e.starts,
                       e.oerr, e.rerr, e.last, out_res.delta_lon, out_res.delta_lat,
                       out_res.is_midpoint, out_res.starts_line, out_res.order_error,
                       out_res.range_error, out_res.last);
          end
        end
      end
    end
    pending = expected_steps.size();
  end
endmodule

>>> tb/sv/tb_polyline_delta_encoder.sv
// Testbench top for the polyline delta encoder: clock, reset, point stimulus, receiver
// stalls, watchdog and verdict. Depends on pde_pkg, pde_if, pde_checker and the block.
module tb_polyline_delta_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LON_MAX = 180000000;
  localparam int LAT_MAX = 90000000;
  // Cycles without any transfer before the run is declared hung. A point at the midpoint
  // limit needs some 64 steps, but a transfer happens between them.
  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst;
  int   fail_count, pending;
  bit   transfer_seen;
  int   tx_idle_pct, rx_idle_pct;
  int   idle_cycles;

  // The tracker of the stimulus: last line id and last point, so that most points are
  // close neighbours and the deeper midpoint paths are reached with fair odds.
  int   recent_line;
  int   last_lon, last_lat;

  pde_in_if  in_pt();
  pde_out_if out_res();

  polyline_delta_encoder DUT (
    .clk(clk), .rst(rst), .in_pt(in_pt), .out_res(out_res)
  );

  pde_checker u_checker (
    .clk(clk), .rst(rst), .in_pt(in_pt), .out_res(out_res),
    .fail_count(fail_count), .pending(pending), .transfer_seen(transfer_seen)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int pick(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Presents one point and holds it until the transfer. Ready only changes at a rising
  // edge, so its value at the falling edge tells whether the next rising edge accepts.
  task automatic send_point(int ln, int slon, int slat, int plon, int plat);
    bit r;
    in_pt.valid      <= 1'b1;
    in_pt.point_line <= ln[23:0];
    in_pt.start_lon  <= slon[28:0];
    in_pt.start_lat  <= slat[27:0];
    in_pt.point_lon  <= plon[28:0];
    in_pt.point_lat  <= plat[27:0];
    do begin
      @(negedge clk);
      r = in_pt.ready;
      @(posedge clk);
    end while (!r);
    recent_line = ln;
    last_lon  = plon;
    last_lat  = plat;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_pt.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // One random point: mostly the same or the next line with a nearby point, sometimes
  // a longer jump that needs midpoints, rarely a jump past the midpoint limit, a
  // descending line or a line id drawn from the whole range.
  task automatic random_point();
    int ln, slon, slat, plon, plat, sel, span;
    sel  = $urandom_range(99);
    ln   = recent_line;
    slon = pick(-LON_MAX, LON_MAX);
    slat = pick(-LAT_MAX, LAT_MAX);
    if (sel < 20) ln = recent_line + pick(1, 3);
    else if (sel < 24) ln = recent_line - pick(1, 100);
    else if (sel < 27) ln = int'($urandom_range(24'hffffff));
    if (ln < 0 || ln > 24'hffffff) ln = int'($urandom_range(24'hffffff));
    sel  = $urandom_range(99);
    if (sel < 70) span = 32767;
    else if (sel < 85) span = 40000;
    else if (sel < 97) span = 400000;
    else span = LON_MAX;
    if (ln != recent_line) begin
      plon = clamp(slon + pick(-span, span), LON_MAX);
      plat = clamp(slat + pick(-span, span), LAT_MAX);
    end else begin
      plon = clamp(last_lon + pick(-span, span), LON_MAX);
      plat = clamp(last_lat + pick(-span, span), LAT_MAX);
    end
    if ($urandom_range(19) == 0) plon = ln != recent_line ? slon : last_lon;
    send_point(ln, slon, slat, plon, plat);
  endtask

  // Receiver stalls, redrawn every cycle.
  always @(posedge clk) begin
    if (rst) out_res.ready <= 1'b0;
    else out_res.ready <= $urandom_range(99) >= rx_idle_pct;
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || transfer_seen) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    idle_cycles = 0;
    tx_idle_pct = 30;
    rx_idle_pct = 47;
    recent_line = -1;
    last_lon = 0;
    last_lat = 0;
    in_pt.valid      <= 1'b0;
    in_pt.point_line <= '0;
    in_pt.start_lon  <= '0;
    in_pt.start_lat  <= '0;
    in_pt.point_lon  <= '0;
    in_pt.point_lat  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The first point opens a line from the reset state, and the jump
    // across the whole field range runs into the midpoint limit.
    send_point(0, -LON_MAX, -LAT_MAX, LON_MAX, LAT_MAX);
    send_point(0, 0, 0, LON_MAX - 32767, LAT_MAX);           // same line, small step
    send_point(0, 0, 0, LON_MAX - 65534, LAT_MAX - 100);     // same line, exactly one full step
    send_point(0, 0, 0, LON_MAX - 65535, LAT_MAX - 100);     // same line, a one-unit step
    send_point(1, 1000, 2000, 1000, 2000);                   // zero delta, new line
    send_point(1, 0, 0, 1000, 102000);                       // vertical, upwards
    send_point(1, 0, 0, 1000, -150000);                      // vertical, downwards
    send_point(1, 0, 0, -50000, -200000);                    // longitude is major
    send_point(1, 0, 0, 70000, -160000);
    send_point(1, 0, 0, -230000, 20000);                     // longitude is major
    send_point(1, 0, 0, -130000, -120000);
    send_point(1, 0, 0, -130000, -120000);                   // repeated point
    send_point(24'hffffff, LON_MAX, LAT_MAX, LON_MAX, LAT_MAX - 32767);
    send_point(5, -LON_MAX, LAT_MAX, -LON_MAX + 32767, LAT_MAX);  // descending line
    send_point(5, 0, 0, LON_MAX, -LAT_MAX);                  // limit from the far side
    send_point(3, 123456, -654321, 123456 - 32768, -654321 + 32768);  // descending again
    send_point(4, -1, -1, 0, 0);
    send_point(4, 0, 0, 40000, 40000);                       // diagonal, equal axes
    send_point(24'h800000, 0, 0, -LON_MAX, LAT_MAX);

    // Random part in three phases of stalls.
    repeat (145) random_point();
    tx_idle_pct = 47;
    rx_idle_pct = 30;
    repeat (145) random_point();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (145) random_point();
    in_pt.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
